// File: hdl/running_statistics_accumulator_core_macros.svh
// Assertion macros shared by the running statistics accumulator checkers.
`ifndef RUNNING_STATISTICS_ACCUMULATOR_CORE_MACROS_SVH
`define RUNNING_STATISTICS_ACCUMULATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rsa_pkg.sv
// Shared widths, codes and the slot record type of the running statistics accumulator.
`timescale 1ns / 1ps

package rsa_pkg;

   localparam int SLOTS_DEFAULT = 64;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 6;
   localparam int SAMPLE_W = 32;
   localparam int STAMP_W  = 48;
   localparam int COUNT_W  = 32;
   localparam int TOTAL_W  = 64;
   localparam int MEAN_W   = 48;
   localparam int DEV_W    = 64;
   localparam int FRAC_W   = 16;

   // Request payload layout, slot in the low bits
   localparam int REQ_DATA_W   = 88;
   localparam int SAMPLE_LSB   = SLOT_W;
   localparam int STAMP_LSB    = SLOT_W + SAMPLE_W;

   // Serial arithmetic
   localparam int MAG_W       = MEAN_W;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int INC_SHIFT   = 32;
   localparam int DIV_STEPS   = MAG_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int MUL_DIGITS  = MAG_W / 2;
   localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
   localparam int MULT_W      = MAG_W + 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_START    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   // Status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_NOT_ENABLED = 1'b1;

   // Saturation limits of the total
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

   // One slot's contents; count sits in the lowest bits, stamp in the highest
   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [DEV_W-1:0]    devsum;
      logic [MEAN_W-1:0]   mean;
      logic [TOTAL_W-1:0]  total;
      logic [SAMPLE_W-1:0] max_seen;
      logic [SAMPLE_W-1:0] min_seen;
      logic [COUNT_W-1:0]  count;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

endpackage

// File: hdl/rsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rsa_serial_div.sv
// Radix-2 restoring divider: magnitude of the mean step divided by the sample count.
`timescale 1ns / 1ps

module rsa_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rsa_pkg::MAG_W-1:0]   dividend,
   input  logic [rsa_pkg::COUNT_W-1:0] divisor,
   output logic                        done,
   output logic [rsa_pkg::MAG_W-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rsa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rsa_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [rsa_pkg::COUNT_W-1:0]   dvs_ff, dvs_in;
   logic [rsa_pkg::MAG_W-1:0]     quo_ff, quo_in;

   logic [rsa_pkg::COUNT_W:0]     trial;
   logic [rsa_pkg::COUNT_W:0]     diff;
   logic                          fits;

   // One quotient bit per cycle: shift in the next dividend bit, try to subtract
   assign trial = {rem_ff, quo_ff[rsa_pkg::MAG_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = ~diff[rsa_pkg::COUNT_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = rsa_pkg::DIV_CNT_W'(rsa_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[rsa_pkg::COUNT_W-1:0] : trial[rsa_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[rsa_pkg::MAG_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/rsa_serial_mul.sv
// Radix-4 shift-and-add multiplier for the deviation increment.
`timescale 1ns / 1ps

module rsa_serial_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rsa_pkg::MAG_W-1:0]  mcand,
   input  logic [rsa_pkg::MAG_W-1:0]  mplier,
   output logic                       done,
   output logic [rsa_pkg::PROD_W-1:0] product
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rsa_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rsa_pkg::MAG_W-1:0]     a_ff, a_in;
   logic [rsa_pkg::MULT_W-1:0]    a3_ff, a3_in;
   logic [rsa_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic [rsa_pkg::MULT_W-1:0]    multiple;
   logic [rsa_pkg::MULT_W-1:0]    sum;

   // Multiple of the multiplicand picked by the lowest multiplier digit
   always_comb begin
      case (prod_ff[1:0])
         2'd0:    multiple = '0;
         2'd1:    multiple = {2'b00, a_ff};
         2'd2:    multiple = {1'b0, a_ff, 1'b0};
         default: multiple = a3_ff;
      endcase
   end

   assign sum = {2'b00, prod_ff[rsa_pkg::PROD_W-1:rsa_pkg::MAG_W]} + multiple;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      a3_in   = a3_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = rsa_pkg::MUL_CNT_W'(rsa_pkg::MUL_DIGITS - 1);
         a_in    = mcand;
         a3_in   = {2'b00, mcand} + {1'b0, mcand, 1'b0};
         prod_in = {{rsa_pkg::MAG_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         // upper half accumulates, whole word shifts down one digit
         prod_in = {sum, prod_ff[rsa_pkg::MAG_W-1:2]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      a3_ff   <= a3_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// File: hdl/running_statistics_accumulator_core.sv
// Top level of the running statistics accumulator: slot store, sequencer and response register.
`timescale 1ns / 1ps

// Keeps count, min, max, saturating total, Welford mean (signed Q32.16) and
// deviation sum for SLOTS slots, one transaction at a time. An add to a slot
// that already holds samples reads the slot record from RAM, runs the
// bit-serial divider (mean step over the count), takes the quotient, starts
// the radix-4 multiplier, runs it (deviation increment), takes the product
// and loads the response register. Start, stop, a first sample and any
// rejected request read the slot record and then load the response register.
// A new request is taken as soon as the previous one has been placed in the
// response register, even if that response has not yet been taken; while an
// older response is still held, the finished transaction waits for it.
// Slot records hold no meaning until a start writes them; the enable bits
// clear on reset.
module running_statistics_accumulator_core #(
   parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rsa_pkg::ACTION_W-1:0]   req_tuser,  // action
   input  logic [rsa_pkg::REQ_DATA_W-1:0] req_tdata,  // slot, sample, stamp, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_tuser,  // status
   output logic [rsa_pkg::REC_W-1:0]      rsp_tdata   // sample_count, min_seen, max_seen,
                                                      // running_total, running_mean,
                                                      // squared_deviation_sum, latest_stamp
);

   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_MEAN,
      ST_MUL,
      ST_OUT
   } state_type;

   state_type                         state_ff, state_in;
   logic [rsa_pkg::ACTION_W-1:0]      action_ff, action_in;
   logic [ADDR_W-1:0]                 addr_ff, addr_in;
   logic [rsa_pkg::SAMPLE_W-1:0]      sample_ff, sample_in;
   logic [rsa_pkg::STAMP_W-1:0]       stamp_ff, stamp_in;
   logic                              valid_ff, valid_in;
   logic                              status_ff, status_in;
   logic                              write_ff, write_in;
   logic                              dneg_ff, dneg_in;
   logic [rsa_pkg::MAG_W-1:0]         dmag_ff, dmag_in;
   rsa_pkg::slot_rec_type             rec_ff, rec_in;
   logic [SLOTS-1:0]                  enabled_ff, enabled_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_user_ff, rsp_user_in;
   rsa_pkg::slot_rec_type             rsp_data_ff, rsp_data_in;

   logic                              req_accept;
   logic                              out_free;
   logic [rsa_pkg::SLOT_W-1:0]        req_slot;
   logic                              req_valid;
   logic [rsa_pkg::MEAN_W-1:0]        xq;
   logic                              en_hit;

   logic                              ram_wr_en;
   logic                              ram_rd_en;
   logic [rsa_pkg::REC_W-1:0]         ram_rd_data;
   rsa_pkg::slot_rec_type             rd_rec;

   logic                              div_start;
   logic                              div_done;
   logic [rsa_pkg::MAG_W-1:0]         quo;
   logic [rsa_pkg::COUNT_W-1:0]       count_next;
   logic                              mul_start;
   logic                              mul_done;
   logic [rsa_pkg::PROD_W-1:0]        prod;
   logic [rsa_pkg::MAG_W-1:0]         emag;

   logic [rsa_pkg::MAG_W-1:0]         dmag_now;
   logic                              dneg_now;
   logic [rsa_pkg::TOTAL_W:0]         total_sum;
   logic [rsa_pkg::DEV_W:0]           dev_sum;

   // Handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_slot   = req_tdata[rsa_pkg::SLOT_W-1:0];
   assign req_valid  = (int'(req_slot) < SLOTS) &&
                       ((req_tuser == rsa_pkg::ACT_START) ||
                        (req_tuser == rsa_pkg::ACT_ADD) ||
                        (req_tuser == rsa_pkg::ACT_STOP));

   assign rd_rec = rsa_pkg::slot_rec_type'(ram_rd_data);
   assign en_hit = valid_ff && enabled_ff[addr_ff];

   // Sample in Q32.16
   assign xq = {sample_ff, {rsa_pkg::FRAC_W{1'b0}}};

   // Step toward the new sample against the stored mean, as sign and magnitude
   assign dneg_now = $signed(xq) < $signed(rd_rec.mean);
   assign dmag_now = dneg_now ? (rd_rec.mean - xq) : (xq - rd_rec.mean);

   // Saturating count
   assign count_next = (rd_rec.count == '1) ? rd_rec.count : rd_rec.count + 1'b1;

   // Total plus sample, one guard bit to spot overflow
   assign total_sum = {rd_rec.total[rsa_pkg::TOTAL_W-1], rd_rec.total} +
                      {{(rsa_pkg::TOTAL_W + 1 - rsa_pkg::SAMPLE_W)
                        {sample_ff[rsa_pkg::SAMPLE_W-1]}}, sample_ff};

   // Distance of the sample from the updated mean
   assign emag = ($signed(xq) < $signed(rec_ff.mean)) ? (rec_ff.mean - xq)
                                                       : (xq - rec_ff.mean);

   // Deviation sum plus the integer part of the product
   assign dev_sum = {1'b0, rec_ff.devsum} +
                    {1'b0, prod[rsa_pkg::PROD_W-1:rsa_pkg::INC_SHIFT]};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      addr_in      = addr_ff;
      sample_in    = sample_ff;
      stamp_in     = stamp_ff;
      valid_in     = valid_ff;
      status_in    = status_ff;
      write_in     = write_ff;
      dneg_in      = dneg_ff;
      dmag_in      = dmag_ff;
      rec_in       = rec_ff;
      enabled_in   = enabled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      div_start    = 1'b0;
      mul_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_tuser;
               addr_in   = ADDR_W'(req_slot);
               sample_in = req_tdata[rsa_pkg::SAMPLE_LSB +: rsa_pkg::SAMPLE_W];
               stamp_in  = req_tdata[rsa_pkg::STAMP_LSB +: rsa_pkg::STAMP_W];
               valid_in  = req_valid;
               ram_rd_en = 1'b1;
               state_in  = ST_EVAL;
            end
         end

         // Slot record is on the RAM output now
         ST_EVAL: begin
            status_in = rsa_pkg::STATUS_NOT_ENABLED;
            write_in  = 1'b0;
            rec_in    = '0;
            state_in  = ST_OUT;
            if (valid_ff) begin
               unique case (action_ff)
                  rsa_pkg::ACT_START: begin
                     status_in           = rsa_pkg::STATUS_OK;
                     write_in            = 1'b1;
                     enabled_in[addr_ff] = 1'b1;
                  end
                  rsa_pkg::ACT_STOP: begin
                     if (en_hit) begin
                        status_in           = rsa_pkg::STATUS_OK;
                        rec_in              = rd_rec;
                        enabled_in[addr_ff] = 1'b0;
                     end
                  end
                  rsa_pkg::ACT_ADD: begin
                     if (en_hit) begin
                        status_in = rsa_pkg::STATUS_OK;
                        write_in  = 1'b1;
                        if (rd_rec.count == '0) begin
                           // first sample seeds everything
                           rec_in.count    = rsa_pkg::COUNT_W'(1);
                           rec_in.min_seen = sample_ff;
                           rec_in.max_seen = sample_ff;
                           rec_in.total    = {{(rsa_pkg::TOTAL_W - rsa_pkg::SAMPLE_W)
                                               {sample_ff[rsa_pkg::SAMPLE_W-1]}}, sample_ff};
                           rec_in.mean     = xq;
                           rec_in.devsum   = '0;
                           rec_in.stamp    = stamp_ff;
                        end else begin
                           rec_in          = rd_rec;
                           rec_in.count    = count_next;
                           rec_in.stamp    = stamp_ff;
                           if ($signed(sample_ff) < $signed(rd_rec.min_seen)) begin
                              rec_in.min_seen = sample_ff;
                           end
                           if ($signed(sample_ff) > $signed(rd_rec.max_seen)) begin
                              rec_in.max_seen = sample_ff;
                           end
                           if (total_sum[rsa_pkg::TOTAL_W] != total_sum[rsa_pkg::TOTAL_W-1]) begin
                              rec_in.total = total_sum[rsa_pkg::TOTAL_W] ? rsa_pkg::TOTAL_MIN
                                                                         : rsa_pkg::TOTAL_MAX;
                           end else begin
                              rec_in.total = total_sum[rsa_pkg::TOTAL_W-1:0];
                           end
                           dneg_in   = dneg_now;
                           dmag_in   = dmag_now;
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Mean moves by the truncated quotient
         ST_DIV: begin
            if (div_done) begin
               rec_in.mean = dneg_ff ? (rec_ff.mean - quo) : (rec_ff.mean + quo);
               state_in    = ST_MEAN;
            end
         end

         ST_MEAN: begin
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end

         // Saturating deviation update
         ST_MUL: begin
            if (mul_done) begin
               rec_in.devsum = dev_sum[rsa_pkg::DEV_W] ? '1 : dev_sum[rsa_pkg::DEV_W-1:0];
               state_in      = ST_OUT;
            end
         end

         // Hand the result to the response register and commit the record
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = (status_ff == rsa_pkg::STATUS_OK) ? rec_ff : '0;
               ram_wr_en    = write_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff   <= action_in;
      addr_ff     <= addr_in;
      sample_ff   <= sample_in;
      stamp_ff    <= stamp_in;
      valid_ff    <= valid_in;
      status_ff   <= status_in;
      write_ff    <= write_in;
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      rec_ff      <= rec_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot record store
   rsa_ram #(
      .WIDTH (rsa_pkg::REC_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (rec_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(req_slot)),
      .rd_data (ram_rd_data)
   );

   // Mean step: |d| / count
   rsa_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dmag_now),
      .divisor  (count_next),
      .done     (div_done),
      .quotient (quo)
   );

   // Deviation increment: |d| * |e|
   rsa_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (dmag_ff),
      .mplier  (emag),
      .done    (mul_done),
      .product (prod)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/rsa_checker.sv
// Port-level checker for the running statistics accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "running_statistics_accumulator_core_macros.svh"

module rsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [rsa_pkg::ACTION_W-1:0]   req_tuser,
   input logic [rsa_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic                           rsp_tuser,
   input logic [rsa_pkg::REC_W-1:0]      rsp_tdata
);

   localparam int MIN_LSB = rsa_pkg::COUNT_W;
   localparam int MAX_LSB = rsa_pkg::COUNT_W + rsa_pkg::SAMPLE_W;

   logic req_accept;
   logic rsp_ok;
   logic rsp_stall;
   logic rsp_reject;
   logic rsp_blank;
   logic rsp_kept;
   logic min_le_max;
   logic [rsa_pkg::SAMPLE_W-1:0] rsp_min;
   logic [rsa_pkg::SAMPLE_W-1:0] rsp_max;
   logic [rsa_pkg::REC_W:0]      rsp_word;
   logic [rsa_pkg::REC_W:0]      rsp_word_ff;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_ok     = rsp_tvalid && (rsp_tuser == rsa_pkg::STATUS_OK);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_reject = rsp_tvalid && (rsp_tuser == rsa_pkg::STATUS_NOT_ENABLED);
   assign rsp_blank  = (rsp_tdata == '0);
   assign rsp_min    = rsp_tdata[MIN_LSB +: rsa_pkg::SAMPLE_W];
   assign rsp_max    = rsp_tdata[MAX_LSB +: rsa_pkg::SAMPLE_W];
   assign min_le_max = $signed(rsp_min) <= $signed(rsp_max);
   assign rsp_word   = {rsp_tuser, rsp_tdata};

   // Previous cycle's response, for the hold check
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word;
   end

   assign rsp_kept = rsp_tvalid && (rsp_word == rsp_word_ff);

   // A stalled response holds its payload
   `RSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_kept, "stalled response changed")

   // One transaction in flight: no second request right after an accept
   `RSA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_accept, !req_tready, "request while busy")

   // Rejected transactions carry an all-zero payload
   `RSA_ASSERT_SAME(a_reject_zero, clock, reset, rsp_reject, rsp_blank, "reject with data")

   // Reported minimum never exceeds the maximum
   `RSA_ASSERT_SAME(a_min_le_max, clock, reset, rsp_ok, min_le_max, "minimum above maximum")

endmodule

bind running_statistics_accumulator_core rsa_checker u_rsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/running_statistics_accumulator_core_tb.sv
// Self-checking bench for the running statistics accumulator: directed table, then random traffic.
`timescale 1ns / 1ps

module running_statistics_accumulator_core_tb;

   // One response: status plus the slot record it reports
   typedef struct {
      logic                  status;
      rsa_pkg::slot_rec_type rec;
   } stats_result_type;

   // One request, with an optional hand-written expectation
   typedef struct {
      logic [rsa_pkg::ACTION_W-1:0] action;
      logic [rsa_pkg::SLOT_W-1:0]   slot;
      logic [rsa_pkg::SAMPLE_W-1:0] sample;
      logic [rsa_pkg::STAMP_W-1:0]  stamp;
      bit                           typed;
      stats_result_type             want;
   } stim_row_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rsa_pkg::ACTION_W-1:0]   req_tuser  = rsa_pkg::ACT_START;  // action
   logic [rsa_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // slot, sample, stamp, zero pad
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           rsp_tuser;        // status
   logic [rsa_pkg::REC_W-1:0]      rsp_tdata;        // count, min, max, total, mean,
                                                     // deviation sum, stamp

   running_statistics_accumulator_core #(
      .SLOTS(rsa_pkg::SLOTS_DEFAULT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   // Predicted slot contents
   bit                                  acc_enabled [rsa_pkg::SLOTS_DEFAULT];
   logic [rsa_pkg::COUNT_W-1:0]         acc_count   [rsa_pkg::SLOTS_DEFAULT];
   logic signed [rsa_pkg::SAMPLE_W-1:0] acc_min     [rsa_pkg::SLOTS_DEFAULT];
   logic signed [rsa_pkg::SAMPLE_W-1:0] acc_max     [rsa_pkg::SLOTS_DEFAULT];
   logic signed [63:0]                  acc_total   [rsa_pkg::SLOTS_DEFAULT];
   logic signed [63:0]                  acc_mean    [rsa_pkg::SLOTS_DEFAULT];
   logic [rsa_pkg::DEV_W-1:0]           acc_devsum  [rsa_pkg::SLOTS_DEFAULT];
   logic [rsa_pkg::STAMP_W-1:0]         acc_stamp   [rsa_pkg::SLOTS_DEFAULT];

   stats_result_type expected_stats_q[$];
   stim_row_type     directed_rows[$];

   int  error_count = 0;
   int  rsp_seen    = 0;
   int  items_sent  = 0;
   int  n_start = 0, n_add = 0, n_stop = 0, n_reserved = 0, n_rejected = 0;
   int  n_welford = 0, n_dev_sat = 0;
   bit  sender_calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #(25_000_000);
      $display("[running_statistics_accumulator_core] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("response %0d: %s got %h expected %h", rsp_seen, field, got, want);
      error_count++;
   endtask

   // Applies one transaction to the predicted slot state and forms its response
   task automatic stats_update(input logic [rsa_pkg::ACTION_W-1:0] action,
                               input logic [rsa_pkg::SLOT_W-1:0] slot,
                               input logic signed [rsa_pkg::SAMPLE_W-1:0] x,
                               input logic [rsa_pkg::STAMP_W-1:0] stamp,
                               output stats_result_type res);
      logic signed [63:0] xq, d, e, new_mean;
      logic [63:0]        d_mag, e_mag, quot, incr;
      logic [127:0]       prod;
      logic signed [64:0] sum;
      bit                 hit;
      hit = 1'b0;
      case (action)
         rsa_pkg::ACT_START: begin
            n_start++;
            acc_enabled[slot] = 1'b1;
            acc_count[slot]   = '0;
            acc_min[slot]     = '0;
            acc_max[slot]     = '0;
            acc_total[slot]   = '0;
            acc_mean[slot]    = '0;
            acc_devsum[slot]  = '0;
            acc_stamp[slot]   = '0;
            hit = 1'b1;
         end
         rsa_pkg::ACT_ADD: begin
            n_add++;
            if (acc_enabled[slot]) begin
               xq = {{16{x[31]}}, x, 16'd0};
               if (acc_count[slot] == '0) begin
                  // first sample seeds everything
                  acc_count[slot]  = rsa_pkg::COUNT_W'(1);
                  acc_min[slot]    = x;
                  acc_max[slot]    = x;
                  acc_total[slot]  = {{32{x[31]}}, x};
                  acc_mean[slot]   = xq;
                  acc_devsum[slot] = '0;
               end else begin
                  n_welford++;
                  d = xq - acc_mean[slot];
                  if (acc_count[slot] != '1) acc_count[slot]++;
                  if (x < acc_min[slot]) acc_min[slot] = x;
                  if (x > acc_max[slot]) acc_max[slot] = x;
                  // saturating total
                  sum = {acc_total[slot][63], acc_total[slot]} + {{33{x[31]}}, x};
                  if (sum[64] != sum[63])
                     acc_total[slot] = sum[64] ? rsa_pkg::TOTAL_MIN : rsa_pkg::TOTAL_MAX;
                  else
                     acc_total[slot] = sum[63:0];
                  // mean step, quotient truncated toward zero
                  d_mag    = d[63] ? -d : d;
                  quot     = d_mag / {32'd0, acc_count[slot]};
                  new_mean = d[63] ? acc_mean[slot] - quot : acc_mean[slot] + quot;
                  e        = xq - new_mean;
                  e_mag    = e[63] ? -e : e;
                  // deviation increment, fraction dropped, saturating
                  prod = {64'd0, d_mag} * {64'd0, e_mag};
                  incr = (prod[127:96] != '0) ? '1 : prod[95:32];
                  acc_devsum[slot] = (acc_devsum[slot] > ~incr) ? '1
                                                                : acc_devsum[slot] + incr;
                  acc_mean[slot] = new_mean;
                  if (acc_devsum[slot] == '1) n_dev_sat++;
               end
               acc_stamp[slot] = stamp;
               hit = 1'b1;
            end
         end
         rsa_pkg::ACT_STOP: begin
            n_stop++;
            if (acc_enabled[slot]) begin
               acc_enabled[slot] = 1'b0;
               hit = 1'b1;
            end
         end
         default: n_reserved++;
      endcase
      res.rec = '0;
      if (hit) begin
         res.status       = rsa_pkg::STATUS_OK;
         res.rec.count    = acc_count[slot];
         res.rec.min_seen = acc_min[slot];
         res.rec.max_seen = acc_max[slot];
         res.rec.total    = acc_total[slot];
         res.rec.mean     = acc_mean[slot][rsa_pkg::MEAN_W-1:0];
         res.rec.devsum   = acc_devsum[slot];
         res.rec.stamp    = acc_stamp[slot];
      end else begin
         res.status = rsa_pkg::STATUS_NOT_ENABLED;
         n_rejected++;
      end
   endtask

   task automatic add_row(input logic [rsa_pkg::ACTION_W-1:0] action,
                          input logic [rsa_pkg::SLOT_W-1:0] slot,
                          input logic [rsa_pkg::SAMPLE_W-1:0] sample,
                          input logic [rsa_pkg::STAMP_W-1:0] stamp,
                          input bit typed, input logic status,
                          input rsa_pkg::slot_rec_type rec);
      stim_row_type row;
      row.action      = action;
      row.slot        = slot;
      row.sample      = sample;
      row.stamp       = stamp;
      row.typed       = typed;
      row.want.status = status;
      row.want.rec    = rec;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offers one request after a random gap and records what it should return
   task automatic send_item(input stim_row_type row);
      stats_result_type predicted;
      int               gap, r;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!sender_calm) begin
         if (r >= 90)      gap = $urandom_range(8, 60);
         else if (r >= 50) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.action;
      req_tdata  <= {2'b00, row.stamp, row.sample, row.slot};
      do @(posedge clock); while (!req_tready);
      stats_update(row.action, row.slot, row.sample, row.stamp, predicted);
      expected_stats_q.insert(expected_stats_q.size(), row.typed ? row.want : predicted);
      items_sent++;
   endtask

   task automatic check_stats(input logic status, input rsa_pkg::slot_rec_type got);
      stats_result_type want;
      if (expected_stats_q.size() == 0) begin
         report_mismatch("unsolicited response, status", 64'(status), 64'd0);
         return;
      end
      want = expected_stats_q.pop_front();
      if (status !== want.status)
         report_mismatch("status", 64'(status), 64'(want.status));
      if (got.count !== want.rec.count)
         report_mismatch("sample_count", 64'(got.count), 64'(want.rec.count));
      if (got.min_seen !== want.rec.min_seen)
         report_mismatch("min_seen", 64'(got.min_seen), 64'(want.rec.min_seen));
      if (got.max_seen !== want.rec.max_seen)
         report_mismatch("max_seen", 64'(got.max_seen), 64'(want.rec.max_seen));
      if (got.total !== want.rec.total)
         report_mismatch("running_total", got.total, want.rec.total);
      if (got.mean !== want.rec.mean)
         report_mismatch("running_mean", 64'(got.mean), 64'(want.rec.mean));
      if (got.devsum !== want.rec.devsum)
         report_mismatch("squared_deviation_sum", got.devsum, want.rec.devsum);
      if (got.stamp !== want.rec.stamp)
         report_mismatch("latest_stamp", 64'(got.stamp), 64'(want.rec.stamp));
   endtask

   // Response side: random back-pressure, one long hold-off to fill the block
   initial begin
      int stall_left, r;
      bit calm, long_done;
      stall_left = 0;
      calm       = 1'b0;
      long_done  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            check_stats(rsp_tuser, rsp_tdata);
            rsp_seen++;
            if ($urandom_range(0, 99) == 0) calm = !calm;
         end
         if (!long_done && rsp_seen >= 500) begin
            long_done  = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!calm) begin
               if (r < 20)      stall_left = $urandom_range(1, 3);
               else if (r < 23) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   // Request side: directed table, then random traffic
   initial begin
      stim_row_type               row;
      int                         r;
      logic [rsa_pkg::SLOT_W-1:0] work_slots [8];
      for (int k = 0; k < 8; k++) work_slots[k] = rsa_pkg::SLOT_W'($urandom_range(0, 63));

      // adds and stops to idle slots, reserved action
      add_row(rsa_pkg::ACT_ADD, 6'd5, 32'd7, 48'd1, 1'b1, rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_STOP, 6'd5, 32'd0, 48'd0, 1'b1, rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_RESERVED, 6'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
              rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_START, 6'd0, 32'd0, 48'd0, 1'b1, rsa_pkg::STATUS_OK, '0);
      // first sample at the negative extreme, latest stamp at its top
      add_row(rsa_pkg::ACT_ADD, 6'd0, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1,
              rsa_pkg::STATUS_OK,
              '{stamp: 48'hFFFF_FFFF_FFFF, devsum: 64'd0, mean: 48'h8000_0000_0000,
                total: 64'hFFFF_FFFF_8000_0000, max_seen: 32'h8000_0000,
                min_seen: 32'h8000_0000, count: 32'd1});
      // swinging between extremes drives the deviation sum into saturation
      for (int k = 0; k < 6; k++)
         add_row(rsa_pkg::ACT_ADD, 6'd0, (k % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000,
                 48'(k), 1'b0, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_STOP, 6'd0, 32'd0, 48'd0, 1'b0, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd0, 32'd3, 48'd3, 1'b1, rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_START, 6'd63, 32'd0, 48'd0, 1'b1, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd63, 32'd0, 48'd0, 1'b1, rsa_pkg::STATUS_OK,
              '{stamp: 48'd0, devsum: 64'd0, mean: 48'd0, total: 64'd0,
                max_seen: 32'd0, min_seen: 32'd0, count: 32'd1});
      // small values exercise mean truncation toward zero
      add_row(rsa_pkg::ACT_ADD, 6'd63, 32'hFFFF_FFFF, 48'd1, 1'b0, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd63, 32'd1, 48'd2, 1'b0, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd63, 32'h7FFF_FFFF, 48'd3, 1'b0, rsa_pkg::STATUS_OK, '0);
      // restart of a live slot clears it
      add_row(rsa_pkg::ACT_START, 6'd63, 32'd9, 48'd9, 1'b1, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd63, 32'd12345, 48'h5555_5555_5555, 1'b1,
              rsa_pkg::STATUS_OK,
              '{stamp: 48'h5555_5555_5555, devsum: 64'd0, mean: 48'h0000_3039_0000,
                total: 64'd12345, max_seen: 32'd12345, min_seen: 32'd12345,
                count: 32'd1});
      add_row(rsa_pkg::ACT_STOP, 6'd63, 32'd0, 48'd0, 1'b0, rsa_pkg::STATUS_OK, '0);
      add_row(rsa_pkg::ACT_STOP, 6'd63, 32'd0, 48'd0, 1'b1, rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_RESERVED, 6'd63, 32'h5A5A_A5A5, 48'h1234_5678_9ABC, 1'b1,
              rsa_pkg::STATUS_NOT_ENABLED, '0);
      add_row(rsa_pkg::ACT_ADD, 6'd42, 32'h0000_0400, 48'hAAAA_AAAA_AAAA, 1'b1,
              rsa_pkg::STATUS_NOT_ENABLED, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) send_item(directed_rows[k]);

      // mostly start-then-add runs on a rotating working set, plus noise
      for (int i = 0; i < 1350; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            work_slots[$urandom_range(0, 7)] = rsa_pkg::SLOT_W'($urandom_range(0, 63));
         row.slot  = work_slots[$urandom_range(0, 7)];
         row.typed = 1'b0;
         row.stamp = {16'($urandom), 32'($urandom)};
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 4))
                  0:       row.sample = 32'h8000_0000;
                  1:       row.sample = 32'h7FFF_FFFF;
                  2:       row.sample = 32'd0;
                  3:       row.sample = 32'hFFFF_FFFF;
                  default: row.sample = 32'd1;
               endcase
            end
            1, 2, 3: row.sample = $urandom;
            default: row.sample = int'($urandom_range(0, 2000)) - 1000;
         endcase
         if (r < 4) begin
            row.action = rsa_pkg::ACT_RESERVED;
            row.slot   = rsa_pkg::SLOT_W'($urandom_range(0, 63));
         end else if (r < 10) begin
            row.action = rsa_pkg::ACT_STOP;
         end else if (r < 14) begin
            row.action = rsa_pkg::ACT_START;
         end else if (r < 20) begin
            row.action = rsa_pkg::ACT_ADD;
            row.slot   = rsa_pkg::SLOT_W'($urandom_range(0, 63));
         end else begin
            row.action = acc_enabled[row.slot] ? rsa_pkg::ACT_ADD : rsa_pkg::ACT_START;
         end
         if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
         send_item(row);
      end
      req_tvalid <= 1'b0;

      while (expected_stats_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run: %0d requests (%0d start, %0d add, %0d stop, %0d reserved), %0d checked",
               items_sent, n_start, n_add, n_stop, n_reserved, rsp_seen);
      $display("Run: %0d refused as not enabled, %0d Welford updates, %0d at devsum ceiling",
               n_rejected, n_welford, n_dev_sat);
      if (error_count == 0)
         $display("[running_statistics_accumulator_core] OK");
      else
         $display("[running_statistics_accumulator_core] ERROR");
      $finish;
   end

endmodule
